[hdl/lat_pkg.sv]
// shared types and constants of the trigger and capture block
`default_nettype none

package lat_pkg;

    // probes wired to the block and trigger steps honored
    localparam int PROBE_COUNT       = 8;
    localparam int MAX_TRIGGER_STEPS = 16;
    localparam int CAPTURE_DEPTH_DEF = 4096;

    // mask of the probe bits that exist
    localparam logic [7:0] PROBE_MASK = 8'((1 << PROBE_COUNT) - 1);

    // reset value of the capture length register
    localparam logic [12:0] LENGTH_RST = 13'd4096;

    // item kinds carried in the input tuser
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    // capture phase as reported in every result word
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_WAIT    = 2'd1,
        PH_CAPTURE = 2'd2
    } t_phase;

    // register slots, 8 bytes apart
    typedef enum logic [1:0] {
        REG_STEPS  = 2'd0,
        REG_COUNT  = 2'd1,
        REG_LENGTH = 2'd2,
        REG_GAP    = 2'd3
    } t_reg;

    // configuration as seen by the sequencer
    typedef struct packed {
        logic [63:0] steps;
        logic [4:0]  count;
        logic [12:0] length;
        logic [15:0] gap;
    } t_cfg;

    // status after one word
    typedef struct packed {
        t_phase      phase;
        logic [4:0]  step;
        logic [12:0] count;
    } t_stat;

endpackage

`default_nettype wire

[hdl/lat_cfg.sv]
// configuration register file behind the apb port
`default_nettype none

module lat_cfg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [4:0]     paddr,
    input  wire logic [63:0]    pwdata,
    output logic      [63:0]    prdata,
    output logic                pready,
    output lat_pkg::t_cfg       o_cfg
);

    logic          wr;
    lat_pkg::t_reg sel;
    lat_pkg::t_cfg r_cfg;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign sel    = lat_pkg::t_reg'(paddr[4:3]);
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steps  <= '0;
            r_cfg.count  <= '0;
            r_cfg.length <= lat_pkg::LENGTH_RST;
            r_cfg.gap    <= '0;
        end else if (wr) begin
            unique case (sel)
                lat_pkg::REG_STEPS:  r_cfg.steps  <= pwdata;
                lat_pkg::REG_COUNT:  r_cfg.count  <= pwdata[4:0];
                lat_pkg::REG_LENGTH: r_cfg.length <= pwdata[12:0];
                lat_pkg::REG_GAP:    r_cfg.gap    <= pwdata[15:0];
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (sel)
            lat_pkg::REG_STEPS:  prdata = r_cfg.steps;
            lat_pkg::REG_COUNT:  prdata = 64'(r_cfg.count);
            lat_pkg::REG_LENGTH: prdata = 64'(r_cfg.length);
            lat_pkg::REG_GAP:    prdata = 64'(r_cfg.gap);
        endcase
    end

endmodule

`default_nettype wire

[hdl/lat_buf.sv]
// sample buffer, one write port and one registered read port
`default_nettype none

module lat_buf #(
    parameter int CAPTURE_DEPTH = lat_pkg::CAPTURE_DEPTH_DEF,
    localparam int AW           = $clog2(CAPTURE_DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [7:0]    i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [7:0]    o_rd_data
);

    logic [7:0] r_mem [CAPTURE_DEPTH];
    logic [7:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    // store a sample
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/lat_ctrl.sv]
// trigger walker and capture sequencer
`default_nettype none

module lat_ctrl #(
    parameter int CAPTURE_DEPTH = lat_pkg::CAPTURE_DEPTH_DEF,
    localparam int AW           = $clog2(CAPTURE_DEPTH),
    localparam int CW           = $clog2(CAPTURE_DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lat_pkg::t_cfg i_cfg,
    input  wire logic          i_accept,
    input  wire logic [1:0]    i_op,
    input  wire logic [7:0]    i_probes,
    output lat_pkg::t_stat     o_stat,
    output logic      [CW-1:0] o_count,
    output logic               o_wr_en,
    output logic      [AW-1:0] o_wr_addr,
    output logic      [7:0]    o_wr_data
);

    localparam int WW = (CW > 13) ? CW : 13;

    lat_pkg::t_phase r_phase, n_phase;
    logic [4:0]      r_step, n_step;
    logic [CW-1:0]   r_count, n_count;
    logic [15:0]     r_gap, n_gap;

    logic [4:0]    eff_steps;
    logic [WW-1:0] len_w;
    logic [CW-1:0] eff_len;
    logic [7:0]    sample;
    logic [3:0]    cur_step;
    logic          hit;
    logic [4:0]    step_inc;
    logic [CW-1:0] count_inc;
    lat_pkg::t_op  op;

    assign op = lat_pkg::t_op'(i_op);

    // effective step count and capture length
    assign eff_steps = (i_cfg.count > 5'(lat_pkg::MAX_TRIGGER_STEPS))
                     ? 5'(lat_pkg::MAX_TRIGGER_STEPS) : i_cfg.count;

    always_comb begin
        len_w = WW'(i_cfg.length);
        if (len_w == '0) begin
            len_w = WW'(1);
        end else if (len_w > WW'(CAPTURE_DEPTH)) begin
            len_w = WW'(CAPTURE_DEPTH);
        end
        eff_len = CW'(len_w);
    end

    // step match on this sample
    assign sample    = i_probes & lat_pkg::PROBE_MASK;
    assign cur_step  = i_cfg.steps[{r_step[3:0], 2'b00} +: 4];
    assign hit       = (sample[cur_step[2:0]] == cur_step[3]);
    assign step_inc  = r_step + 5'd1;
    assign count_inc = r_count + CW'(1);

    // next state and buffer write
    always_comb begin
        n_phase   = r_phase;
        n_step    = r_step;
        n_count   = r_count;
        n_gap     = r_gap;
        o_wr_en   = 1'b0;
        o_wr_addr = AW'(r_count);
        if (i_accept) begin
            unique case (op)
                lat_pkg::OP_START: begin
                    n_step  = '0;
                    n_count = '0;
                    n_gap   = '0;
                    n_phase = (eff_steps == '0) ? lat_pkg::PH_CAPTURE : lat_pkg::PH_WAIT;
                end
                lat_pkg::OP_TICK: begin
                    unique case (r_phase)
                        lat_pkg::PH_WAIT: begin
                            if (hit) begin
                                n_step = step_inc;
                                if (step_inc >= eff_steps) begin
                                    // triggering sample goes to entry zero
                                    o_wr_en   = 1'b1;
                                    o_wr_addr = '0;
                                    n_count   = CW'(1);
                                    n_gap     = i_cfg.gap;
                                    n_phase   = (eff_len <= CW'(1))
                                              ? lat_pkg::PH_IDLE : lat_pkg::PH_CAPTURE;
                                end
                            end
                        end
                        lat_pkg::PH_CAPTURE: begin
                            if (r_count >= eff_len) begin
                                n_phase = lat_pkg::PH_IDLE;
                            end else if (r_gap != '0) begin
                                n_gap = r_gap - 16'd1;
                            end else begin
                                o_wr_en = 1'b1;
                                n_count = count_inc;
                                n_gap   = i_cfg.gap;
                                if (count_inc >= eff_len) begin
                                    n_phase = lat_pkg::PH_IDLE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    assign o_wr_data    = sample;
    assign o_count      = r_count;
    assign o_stat.phase = n_phase;
    assign o_stat.step  = n_step;
    assign o_stat.count = 13'(n_count);

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lat_pkg::PH_IDLE;
            r_step  <= '0;
            r_count <= '0;
            r_gap   <= '0;
        end else begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_count <= n_count;
            r_gap   <= n_gap;
        end
    end

    // every stored sample advances the count past its entry
    a_wr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |=> (r_count == CW'($past(o_wr_addr)) + CW'(1)))
        else $error("count did not follow buffer write");

    // nothing is stored while the trigger is still pending
    a_wait_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == lat_pkg::PH_WAIT) |-> (r_count == '0))
        else $error("samples held while waiting on trigger");

    // a start always arms from a clean slate
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (op == lat_pkg::OP_START))
        |=> (r_step == '0 && r_count == '0 && r_phase != lat_pkg::PH_IDLE))
        else $error("start did not rearm");

endmodule

`default_nettype wire

[hdl/logic_analyzer_trigger_capture.sv]
// top level: stream ports, apb registers, sequencer, buffer and output stage
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser op, tdata probes/read_index
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata read result and status
// apb       in   psel/penable/pwrite/pready     pwdata 64 bit, paddr 8*i
//
// one word accepted per cycle while m_axis does not stall; the sequencer and the
// buffer read register load on the accept, then the output register loads and the
// result is offered on m_axis; each word uses the buffer at most once
// (write port on a tick, read port on a read), so words follow back to back
// a stall on m_axis holds the middle stage and drops s_axis_tready
// reset is synchronous and needs no clearing pass; unread entries never show
`default_nettype none

module logic_analyzer_trigger_capture #(
    parameter int CAPTURE_DEPTH = lat_pkg::CAPTURE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input words
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // probes[7:0], read_index[19:8]
    input  wire logic [1:0]  s_axis_tuser,   // op[1:0]
    // result words
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // read_data[7:0], read_valid[8],
                                             // phase[10:9], trigger_step[15:11],
                                             // captured_count[28:16]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);

    localparam int AW = $clog2(CAPTURE_DEPTH);
    localparam int CW = $clog2(CAPTURE_DEPTH + 1);
    localparam int WW = (CW > 13) ? CW : 13;

    lat_pkg::t_cfg  cfg;
    lat_pkg::t_stat stat;
    logic [CW-1:0]  count;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [7:0]     wr_data;
    logic [7:0]     rd_data;

    logic           accept;
    logic [WW-1:0]  idx_w;
    logic           rd_hit;
    logic           p1_adv;

    logic           r_p1_valid;
    logic           r_p1_rvalid;
    lat_pkg::t_stat r_p1_stat;
    logic           r_out_valid;
    logic [31:0]    r_out_data;

    lat_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lat_ctrl #(.CAPTURE_DEPTH(CAPTURE_DEPTH)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_accept  (accept),
        .i_op      (s_axis_tuser),
        .i_probes  (s_axis_tdata[7:0]),
        .o_stat    (stat),
        .o_count   (count),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    lat_buf #(.CAPTURE_DEPTH(CAPTURE_DEPTH)) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept && rd_hit),
        .i_rd_addr (AW'(s_axis_tdata[19:8])),
        .o_rd_data (rd_data)
    );

    // handshake and read decision
    assign p1_adv        = r_p1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_p1_valid || p1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign idx_w         = WW'(s_axis_tdata[19:8]);
    assign rd_hit        = (lat_pkg::t_op'(s_axis_tuser) == lat_pkg::OP_READ)
                         && (idx_w < WW'(count)) && (idx_w < WW'(CAPTURE_DEPTH));

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_p1_valid <= 1'b1;
            end else if (p1_adv) begin
                r_p1_valid <= 1'b0;
            end
            if (p1_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p1_rvalid <= rd_hit;
            r_p1_stat   <= stat;
        end
        if (p1_adv) begin
            r_out_data <= {3'b000, r_p1_stat.count, r_p1_stat.step, r_p1_stat.phase,
                           r_p1_rvalid, (r_p1_rvalid ? rd_data : 8'h00)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
